[src/yrgb_pkg.sv]
// Shared types, constants and helper functions for the YUV to RGB converter.
// Used by yrgb_mix and by the top level yuv_to_rgb_fixed_point; no dependencies.
package yrgb_pkg;

    localparam int SCALE_SHIFT = 3;
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_LUMA_OFFSET = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CB_OFFSET   = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CR_OFFSET   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LUMA_GAIN   = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CB_TO_BLUE  = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CB_TO_GREEN = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CR_TO_GREEN = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CR_TO_RED   = 4'd7;

    // Output byte orders.
    localparam int ORDER_RGB24 = 0;
    localparam int ORDER_BGR24 = 1;
    localparam int ORDER_RGBA  = 2;
    localparam int ORDER_BGRA  = 3;
    localparam int ORDER_ARGB  = 4;
    localparam int ORDER_ABGR  = 5;
    localparam int DEFAULT_OUTPUT_ORDER = ORDER_RGB24;

    // High halves of the five coefficient products.
    typedef struct packed {
        logic signed [15:0] yy;
        logic signed [15:0] u2b;
        logic signed [15:0] u2g;
        logic signed [15:0] v2g;
        logic signed [15:0] v2r;
    } prod_t;

    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] s;
        s = signed'({a[15], a}) + signed'({b[15], b});
        if (s > 17'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (s < -17'sd32768)
        begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    function automatic logic [7:0] clip255(input logic signed [15:0] v);
        if (v[15])
        begin
            return 8'd0;
        end
        else if (v > 16'sd255)
        begin
            return 8'hFF;
        end
        return v[7:0];
    endfunction

endpackage

[src/yuv_to_rgb_fixed_point.sv]
// Top level of the fixed-point YUV to RGB pixel converter.
// Depends on yrgb_pkg and instantiates yrgb_mix.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one pixel per transaction:
//   luma, blue chroma and red chroma bytes. Output stream (m_tvalid/m_tready/
//   m_tdata) carries one packed 32-bit pixel word per input transaction, in order.
//   Eight 16-bit signed registers (offsets and coefficients) are written through
//   cfg_we/cfg_addr/cfg_data; write them only while no pixel is in flight.
//   Indexes 8 and above are ignored.
//   Pipeline: prescale register, product register, output register. Throughput is
//   one pixel per clock while m_tready stays high; the product stage holds five
//   16x16 signed multiplies side by side. Each stage takes new data when it is
//   empty or its contents move on, so bubbles are squeezed out. When the
//   receiver holds m_tready low the pipeline fills and s_tready drops once all
//   three stages hold a pixel.
//   Reset clears all stage valid flags and every configuration register to zero.
//   OUTPUT_ORDER selects RGB24, BGR24, RGBA, BGRA, ARGB or ABGR packing.
module yuv_to_rgb_fixed_point #(
    parameter int OUTPUT_ORDER = yrgb_pkg::DEFAULT_OUTPUT_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // luma, chroma_blue, chroma_red
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // pixel_word
    input  logic                                cfg_we,
    input  logic [yrgb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [yrgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [15:0] luma_offset_reg;
    logic signed [15:0] cb_offset_reg;
    logic signed [15:0] cr_offset_reg;
    logic signed [15:0] luma_gain_reg;
    logic signed [15:0] cb_to_blue_reg;
    logic signed [15:0] cb_to_green_reg;
    logic signed [15:0] cr_to_green_reg;
    logic signed [15:0] cr_to_red_reg;

    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               out_valid_reg;
    logic               s1_ready;
    logic               s2_ready;
    logic               out_ready;

    logic signed [15:0] y_reg;
    logic signed [15:0] u_reg;
    logic signed [15:0] v_reg;
    logic signed [15:0] y_next;
    logic signed [15:0] u_next;
    logic signed [15:0] v_next;

    yrgb_pkg::prod_t    prod_reg;
    yrgb_pkg::prod_t    prod_next;
    logic [31:0]        word_next;
    logic [31:0]        word_reg;

    logic signed [31:0] p_yy;
    logic signed [31:0] p_u2b;
    logic signed [31:0] p_u2g;
    logic signed [31:0] p_v2g;
    logic signed [31:0] p_v2r;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_offset_reg <= '0;
            cb_offset_reg   <= '0;
            cr_offset_reg   <= '0;
            luma_gain_reg   <= '0;
            cb_to_blue_reg  <= '0;
            cb_to_green_reg <= '0;
            cr_to_green_reg <= '0;
            cr_to_red_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                yrgb_pkg::REG_LUMA_OFFSET: luma_offset_reg <= cfg_data;
                yrgb_pkg::REG_CB_OFFSET:   cb_offset_reg   <= cfg_data;
                yrgb_pkg::REG_CR_OFFSET:   cr_offset_reg   <= cfg_data;
                yrgb_pkg::REG_LUMA_GAIN:   luma_gain_reg   <= cfg_data;
                yrgb_pkg::REG_CB_TO_BLUE:  cb_to_blue_reg  <= cfg_data;
                yrgb_pkg::REG_CB_TO_GREEN: cb_to_green_reg <= cfg_data;
                yrgb_pkg::REG_CR_TO_GREEN: cr_to_green_reg <= cfg_data;
                yrgb_pkg::REG_CR_TO_RED:   cr_to_red_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: a stage can load when it is empty or its contents leave.
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: scale each sample by eight and remove its offset, wrapping to 16 bits.
    always_comb
    begin
        y_next = (16'(s_tdata[7:0])   << yrgb_pkg::SCALE_SHIFT) - luma_offset_reg;
        u_next = (16'(s_tdata[15:8])  << yrgb_pkg::SCALE_SHIFT) - cb_offset_reg;
        v_next = (16'(s_tdata[23:16]) << yrgb_pkg::SCALE_SHIFT) - cr_offset_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_tvalid)
        begin
            y_reg <= y_next;
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    // Stage 2: signed products, high halves kept.
    always_comb
    begin
        p_yy  = y_reg * luma_gain_reg;
        p_u2b = u_reg * cb_to_blue_reg;
        p_u2g = u_reg * cb_to_green_reg;
        p_v2g = v_reg * cr_to_green_reg;
        p_v2r = v_reg * cr_to_red_reg;
        prod_next.yy  = p_yy[31:16];
        prod_next.u2b = p_u2b[31:16];
        prod_next.u2g = p_u2g[31:16];
        prod_next.v2g = p_v2g[31:16];
        prod_next.v2r = p_v2r[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 3: saturating sums, clamp and pack.
    yrgb_mix #(
        .OUTPUT_ORDER (OUTPUT_ORDER)
    ) u_mix (
        .prod       (prod_reg),
        .pixel_word (word_next)
    );

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            word_reg <= word_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted pixel always lands in the first stage.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted pixel did not enter the first stage");

    // Input is only refused when every stage is full and the output is stalled.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready)
        else $error("input refused while the pipeline has room");

    // A pixel in the product stage moves to the output whenever the output can take it.
    a_product_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && out_ready |=> m_tvalid)
        else $error("product stage did not advance to the output");

    // The fixed byte of the packed word matches the selected order.
    a_fixed_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ((OUTPUT_ORDER == yrgb_pkg::ORDER_RGBA || OUTPUT_ORDER == yrgb_pkg::ORDER_BGRA)
                ? (m_tdata[31:24] == yrgb_pkg::ALPHA_BYTE)
             : (OUTPUT_ORDER == yrgb_pkg::ORDER_ARGB || OUTPUT_ORDER == yrgb_pkg::ORDER_ABGR)
                ? (m_tdata[7:0] == yrgb_pkg::ALPHA_BYTE)
             : (m_tdata[31:24] == 8'd0)))
        else $error("fixed byte of the pixel word is wrong");
`endif

endmodule

[src/yrgb_mix.sv]
// Combines the coefficient products into clamped R, G, B and packs the pixel word.
// Depends on yrgb_pkg for prod_t, the saturating helpers and the order codes.
module yrgb_mix #(
    parameter int OUTPUT_ORDER = yrgb_pkg::DEFAULT_OUTPUT_ORDER
) (
    input  yrgb_pkg::prod_t prod,
    output logic [31:0]     pixel_word
);

    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic signed [15:0] chroma_g;

    always_comb
    begin
        chroma_g = yrgb_pkg::sat_add16(prod.v2g, prod.u2g);
        r = yrgb_pkg::clip255(yrgb_pkg::sat_add16(prod.yy, prod.v2r));
        g = yrgb_pkg::clip255(yrgb_pkg::sat_add16(prod.yy, chroma_g));
        b = yrgb_pkg::clip255(yrgb_pkg::sat_add16(prod.yy, prod.u2b));
    end

    // Byte 0 is the first byte in memory. Unknown orders pack as RGB24.
    always_comb
    begin
        case (OUTPUT_ORDER)
            yrgb_pkg::ORDER_BGR24: pixel_word = {8'd0, r, g, b};
            yrgb_pkg::ORDER_RGBA:  pixel_word = {yrgb_pkg::ALPHA_BYTE, b, g, r};
            yrgb_pkg::ORDER_BGRA:  pixel_word = {yrgb_pkg::ALPHA_BYTE, r, g, b};
            yrgb_pkg::ORDER_ARGB:  pixel_word = {b, g, r, yrgb_pkg::ALPHA_BYTE};
            yrgb_pkg::ORDER_ABGR:  pixel_word = {r, g, b, yrgb_pkg::ALPHA_BYTE};
            default:               pixel_word = {8'd0, b, g, r};
        endcase
    end

endmodule
